// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the stencil sweep block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define JSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jss assertion failed");

// next-cycle implication
`define JSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jss assertion failed");

`endif

// ----- rtl/jss_pkg.sv -----
// ----------------------------------------------------------------------------
// jss_pkg
// types, constants and helpers for the 3d stencil sweep
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jss_pkg;

    localparam int MAX_EDGE_DEF = 64;
    localparam int SAMPLE_BITS  = 32;
    localparam int CFG_W        = 48;
    localparam int CFG_IDX_W    = 3;

    localparam logic [47:0] COEF_RST   = 48'd65536;
    localparam logic [39:0] RECIP_RST  = 40'hFFD5555555;
    localparam logic [17:0] RELAX_RST  = 18'd65536;
    localparam logic [6:0]  SIZE_RST   = 7'd64;
    localparam logic [62:0] SAT63      = {63{1'b1}};
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_X       = 3'd0,
        REG_COEF_Y       = 3'd1,
        REG_COEF_Z       = 3'd2,
        REG_CENTRE_RECIP = 3'd3,
        REG_RELAX        = 3'd4,
        REG_SIZE_X       = 3'd5,
        REG_SIZE_Y       = 3'd6,
        REG_SIZE_Z       = 3'd7
    } t_reg;

    // micro-op sequence for one interior point, run in this order
    typedef enum logic [4:0] {
        OP_RD_XM, OP_RD_YM, OP_RD_YP, OP_RD_ZM, OP_RD_ZP, OP_RD_C,
        OP_MUL_X, OP_MUL_Y, OP_MUL_Z,
        OP_ADD_Y, OP_ADD_Z, OP_SUB_F,
        OP_MUL_Q, OP_ADD_P,
        OP_MUL_R, OP_SUB_N,
        OP_MUL_S, OP_ACC
    } t_op;

    typedef struct packed {
        logic signed [31:0] u_sample;
        logic signed [31:0] f_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] new_value;
        logic [62:0]        residual_sum;
        logic               last_point;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel_rem;
        logic go;
        t_op  op;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic emit;
        logic out_free;
    } t_sts;

    function automatic logic is_mul_op(input t_op op);
        return (op == OP_MUL_X) || (op == OP_MUL_Y) || (op == OP_MUL_Z) ||
               (op == OP_MUL_Q) || (op == OP_MUL_R) || (op == OP_MUL_S);
    endfunction

    // exact add or subtract, saturated to signed 64 bit
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input logic sub);
        logic [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? $unsigned(-x) : $unsigned(x);
    endfunction

    // clamp a 65 bit signed difference to the sample range
    function automatic logic signed [31:0] clamp_sample(input logic [64:0] d);
        if (!d[64] && (|d[63:SAMPLE_BITS-1]))
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        if (d[64] && !(&d[63:SAMPLE_BITS-1]))
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        return d[31:0];
    endfunction

endpackage

// ----- rtl/jss_div.sv -----
// ----------------------------------------------------------------------------
// jss_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jss_div #(
    parameter int DW = 19,
    parameter int VW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quo,
    output logic [VW-1:0] o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [VW:0]   rem_sh;
    logic [VW:0]   diff;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign diff   = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!diff[VW]) begin
                r_rem <= diff[VW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[VW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/jss_mul.sv -----
// ----------------------------------------------------------------------------
// jss_mul
// 64x64 multiplier from four 32x32 partial products, rounding and saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jss_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_neg,
    input  logic               i_sh16,
    input  logic [63:0]        i_a,
    input  logic [63:0]        i_b,
    output logic               o_done,
    output logic [127:0]       o_prod,
    output logic signed [63:0] o_res
);
    import jss_pkg::*;

    logic         r_busy;
    logic [2:0]   r_step;
    logic         r_done;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic         r_neg;
    logic         r_sh16;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_idx;
    logic [127:0] r_acc;
    logic [127:0] r_rnd;
    logic signed [63:0] r_res;

    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [127:0] pp_sh;
    logic [63:0]  v;
    logic         top_nz;

    assign pa = r_step[1] ? r_a[63:32] : r_a[31:0];
    assign pb = r_step[0] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        unique case (r_pp_idx)
            2'd0:    pp_sh = {64'b0, r_pp};
            2'd3:    pp_sh = {r_pp, 64'b0};
            default: pp_sh = {32'b0, r_pp, 32'b0};
        endcase
    end

    assign v      = r_sh16 ? r_rnd[79:16] : r_rnd[95:32];
    assign top_nz = r_sh16 ? (|r_rnd[127:80]) : (|r_rnd[127:96]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == 3'd6);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd6) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_neg  <= i_neg;
            r_sh16 <= i_sh16;
            r_acc  <= '0;
        end else if (r_busy) begin
            if (r_step <= 3'd3) begin
                r_pp     <= pa * pb;
                r_pp_idx <= r_step[1:0];
            end
            if (r_step >= 3'd1 && r_step <= 3'd4) r_acc <= r_acc + pp_sh;
            if (r_step == 3'd5) begin
                r_rnd <= r_acc + (r_sh16 ? 128'h8000 : 128'h8000_0000);
            end
            if (r_step == 3'd6) begin
                if (top_nz || v[63]) r_res <= r_neg ? S64_MIN : S64_MAX;
                else                 r_res <= r_neg ? -$signed(v) : $signed(v);
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
    assign o_res  = r_res;

endmodule

// ----- rtl/jss_dp.sv -----
// ----------------------------------------------------------------------------
// jss_dp
// datapath: config registers, plane stores, index divider, arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jss_dp #(
    parameter int MAX_EDGE = jss_pkg::MAX_EDGE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [jss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jss_pkg::CFG_W-1:0]      i_cfg_data,
    input  jss_pkg::t_in_word              i_in_word,
    input  jss_pkg::t_cmd                  i_cmd,
    output jss_pkg::t_sts                  o_sts,
    output jss_pkg::t_out_word             o_out_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall
);
    import jss_pkg::*;

    localparam int PAD    = MAX_EDGE + 2;
    localparam int EW     = $clog2(PAD + 1);
    localparam int PLW    = $clog2(PAD * PAD + 1);
    localparam int PW     = $clog2(PAD * PAD * PAD + 1);
    localparam int UDEPTH = 2 * PAD * PAD;
    localparam int FDEPTH = PAD * PAD;
    localparam int AW     = $clog2(UDEPTH);
    localparam int FAW    = $clog2(FDEPTH);

    // config
    logic [47:0]        r_coef_x, r_coef_y, r_coef_z;
    logic signed [39:0] r_recip;
    logic [17:0]        r_relax;
    logic [6:0]         r_size_x, r_size_y, r_size_z;

    logic [EW-1:0]  sx, sy, sz, px, py, pz;
    logic [PLW-1:0] r_plane;
    logic [PW-1:0]  r_total;

    // position and index
    logic [PW-1:0]  r_pos;
    logic [PW-1:0]  r_ip;
    logic [PLW-1:0] r_rem;
    logic [EW-1:0]  r_j, r_k;
    logic           r_div_sel;
    logic           emit;
    logic           last;
    logic           wrap;

    logic           div_done;
    logic [PW-1:0]  div_quo;
    logic [PLW-1:0] div_rem;

    // stores
    logic [SAMPLE_BITS-1:0] r_umem [UDEPTH];
    logic [SAMPLE_BITS-1:0] r_fmem [FDEPTH];
    logic [SAMPLE_BITS-1:0] r_urd;
    logic [SAMPLE_BITS-1:0] r_frd;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   r_rd_pend;
    t_op                    r_rd_op;
    logic [AW-1:0]          plane_a, rem_a, pz_a, base_c, xm_a;

    // operands and intermediates
    t_in_word              r_in;
    logic signed [31:0]    r_xm, r_ym, r_yp, r_zm, r_zp, r_uc;
    logic signed [63:0]    r_tx, r_ty, r_tz, r_num, r_q, r_part, r_rt;
    logic signed [31:0]    r_nv;
    logic [62:0]           r_sq;
    logic [62:0]           r_acc_new;
    logic [62:0]           r_resid;
    logic [63:0]           acc_sum;

    logic               mul_start;
    logic               mul_neg;
    logic               mul_sh16;
    logic [63:0]        mul_a, mul_b;
    logic               mul_done;
    logic [127:0]       mul_prod;
    logic signed [63:0] mul_res;
    logic signed [32:0] nb_sum;

    t_out_word r_out;
    logic      r_out_valid;

    // geometry
    assign sx = (int'(r_size_x) > MAX_EDGE) ? EW'(MAX_EDGE) : EW'(r_size_x);
    assign sy = (int'(r_size_y) > MAX_EDGE) ? EW'(MAX_EDGE) : EW'(r_size_y);
    assign sz = (int'(r_size_z) > MAX_EDGE) ? EW'(MAX_EDGE) : EW'(r_size_z);
    assign px = sx + EW'(2);
    assign py = sy + EW'(2);
    assign pz = sz + EW'(2);

    always_ff @(posedge i_clk) begin
        r_plane <= PLW'(py) * PLW'(pz);
        r_total <= PW'(px) * PW'(r_plane);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_x <= COEF_RST;
            r_coef_y <= COEF_RST;
            r_coef_z <= COEF_RST;
            r_recip  <= RECIP_RST;
            r_relax  <= RELAX_RST;
            r_size_x <= SIZE_RST;
            r_size_y <= SIZE_RST;
            r_size_z <= SIZE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_COEF_X:       r_coef_x <= i_cfg_data;
                REG_COEF_Y:       r_coef_y <= i_cfg_data;
                REG_COEF_Z:       r_coef_z <= i_cfg_data;
                REG_CENTRE_RECIP: r_recip  <= i_cfg_data[39:0];
                REG_RELAX:        r_relax  <= i_cfg_data[17:0];
                REG_SIZE_X:       r_size_x <= i_cfg_data[6:0];
                REG_SIZE_Y:       r_size_y <= i_cfg_data[6:0];
                REG_SIZE_Z:       r_size_z <= i_cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    // raster index: p / plane, then rem / pz
    jss_div #(.DW(PW), .VW(PLW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_cmd.div_sel_rem ? PW'(div_rem) : r_pos),
        .i_divisor  (i_cmd.div_sel_rem ? PLW'(pz) : r_plane),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) r_div_sel <= i_cmd.div_sel_rem;
        if (div_done) begin
            if (!r_div_sel) begin
                r_ip  <= div_quo;
                r_rem <= div_rem;
            end else begin
                r_j <= EW'(div_quo);
                r_k <= EW'(div_rem);
            end
        end
    end

    assign emit = (r_ip >= PW'(2)) && (r_ip <= PW'(sx) + PW'(1)) &&
                  (r_j >= EW'(1)) && (r_j <= sy) && (r_k >= EW'(1)) && (r_k <= sz);
    assign last = (r_ip == PW'(sx) + PW'(1)) && (r_j == sy) && (r_k == sz);
    assign wrap = ({1'b0, r_pos} + (PW+1)'(1)) >= {1'b0, r_total};

    // plane addressing; odd plane index keeps the centre plane in the low half
    assign plane_a = AW'(r_plane);
    assign rem_a   = AW'(r_rem);
    assign pz_a    = AW'(pz);
    assign base_c  = rem_a + (r_ip[0] ? AW'(0) : plane_a);
    assign xm_a    = rem_a + (r_ip[0] ? plane_a : AW'(0));

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = base_c;
        if (i_cmd.go) begin
            unique case (i_cmd.op)
                OP_RD_XM: begin rd_en = 1'b1; rd_addr = xm_a;           end
                OP_RD_YM: begin rd_en = 1'b1; rd_addr = base_c - pz_a;  end
                OP_RD_YP: begin rd_en = 1'b1; rd_addr = base_c + pz_a;  end
                OP_RD_ZM: begin rd_en = 1'b1; rd_addr = base_c - AW'(1); end
                OP_RD_ZP: begin rd_en = 1'b1; rd_addr = base_c + AW'(1); end
                OP_RD_C:  begin rd_en = 1'b1; rd_addr = base_c;         end
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_urd <= r_umem[rd_addr];
        if (i_cmd.commit) r_umem[xm_a] <= r_in.u_sample;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en && (i_cmd.op == OP_RD_XM)) r_frd <= r_fmem[FAW'(r_rem)];
        if (i_cmd.commit) r_fmem[FAW'(r_rem)] <= r_in.f_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_pend <= 1'b0;
        else          r_rd_pend <= rd_en;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_op <= i_cmd.op;
        if (r_rd_pend) begin
            unique case (r_rd_op)
                OP_RD_XM: r_xm <= r_urd;
                OP_RD_YM: r_ym <= r_urd;
                OP_RD_YP: r_yp <= r_urd;
                OP_RD_ZM: r_zm <= r_urd;
                OP_RD_ZP: r_zp <= r_urd;
                default:  r_uc <= r_urd;
            endcase
        end
    end

    // multiplier operands
    always_comb begin
        mul_neg  = 1'b0;
        mul_sh16 = 1'b1;
        mul_a    = mag64(r_part);
        mul_b    = mag64(r_part);
        nb_sum   = 33'(r_xm) + 33'(r_in.u_sample);
        unique case (i_cmd.op)
            OP_MUL_X: begin
                nb_sum = 33'(r_xm) + 33'(r_in.u_sample);
                mul_b  = 64'(r_coef_x);
            end
            OP_MUL_Y: begin
                nb_sum = 33'(r_ym) + 33'(r_yp);
                mul_b  = 64'(r_coef_y);
            end
            OP_MUL_Z: begin
                nb_sum = 33'(r_zm) + 33'(r_zp);
                mul_b  = 64'(r_coef_z);
            end
            default: ;
        endcase
        unique case (i_cmd.op)
            OP_MUL_X, OP_MUL_Y, OP_MUL_Z: begin
                mul_neg = nb_sum[32];
                mul_a   = nb_sum[32] ? {31'b0, $unsigned(-nb_sum)} : {31'b0, $unsigned(nb_sum)};
            end
            OP_MUL_Q: begin
                mul_neg  = r_num[63] ^ r_recip[39];
                mul_sh16 = 1'b0;
                mul_a    = mag64(r_num);
                mul_b    = r_recip[39] ? {24'b0, $unsigned(-r_recip)}
                                       : {24'b0, $unsigned(r_recip)};
            end
            OP_MUL_R: begin
                mul_neg = r_part[63];
                mul_b   = 64'(r_relax);
            end
            default: ;
        endcase
    end

    assign mul_start = i_cmd.go && is_mul_op(i_cmd.op);

    jss_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_neg   (mul_neg),
        .i_sh16  (mul_sh16),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod),
        .o_res   (mul_res)
    );

    assign acc_sum = {1'b0, r_resid} + {1'b0, r_sq};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_word;
        if (mul_done) begin
            unique case (i_cmd.op)
                OP_MUL_X: r_tx <= mul_res;
                OP_MUL_Y: r_ty <= mul_res;
                OP_MUL_Z: r_tz <= mul_res;
                OP_MUL_Q: r_q  <= mul_res;
                OP_MUL_R: r_rt <= mul_res;
                OP_MUL_S: r_sq <= ((|mul_prod[127:63])) ? SAT63 : mul_prod[62:0];
                default:  ;
            endcase
        end
        if (i_cmd.go) begin
            unique case (i_cmd.op)
                OP_ADD_Y: r_num  <= sat_add(r_tx, r_ty, 1'b0);
                OP_ADD_Z: r_num  <= sat_add(r_num, r_tz, 1'b0);
                OP_SUB_F: r_num  <= sat_add(r_num, 64'($signed(r_frd)), 1'b1);
                OP_ADD_P: r_part <= sat_add(64'(r_uc), r_q, 1'b0);
                OP_SUB_N: r_nv   <= clamp_sample({{33{r_uc[31]}}, r_uc} - {r_rt[63], r_rt});
                OP_ACC:   r_acc_new <= acc_sum[63] ? SAT63 : acc_sum[62:0];
                default:  ;
            endcase
        end
        if (i_cmd.commit && emit) begin
            r_out.new_value    <= r_nv;
            r_out.residual_sum <= r_acc_new;
            r_out.last_point   <= last;
        end
    end

    // control state: position, residual, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_resid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_pos <= wrap ? '0 : r_pos + PW'(1);
                if (wrap)      r_resid <= '0;
                else if (emit) r_resid <= r_acc_new;
            end
            if (i_cmd.commit && emit) r_out_valid <= 1'b1;
            else if (!i_out_stall)    r_out_valid <= 1'b0;
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.mul_done = mul_done;
    assign o_sts.emit     = emit;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_word     = r_out;
    assign o_out_valid    = r_out_valid;

    `JSS_ASSERT_NEXT(a_out_set, i_clk, i_rst_n, i_cmd.commit && emit, r_out_valid)
    `JSS_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, i_cmd.commit && emit, !(r_out_valid && i_out_stall))

endmodule

// ----- rtl/jss_ctrl.sv -----
// ----------------------------------------------------------------------------
// jss_ctrl
// sequencer: index division, store reads, arithmetic micro-ops, commit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  jss_pkg::t_sts i_sts,
    output jss_pkg::t_cmd o_cmd
);
    import jss_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_GEO0   = 10'b00_0000_0010,
        S_GEO1   = 10'b00_0000_0100,
        S_DIVP   = 10'b00_0000_1000,
        S_DIVR   = 10'b00_0001_0000,
        S_CHK    = 10'b00_0010_0000,
        S_OP     = 10'b00_0100_0000,
        S_WAIT   = 10'b00_1000_0000,
        S_COMMIT = 10'b01_0000_0000,
        S_SPARE  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '{load: 1'b0, div_start: 1'b0, div_sel_rem: 1'b0, go: 1'b0,
                    op: r_op, commit: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_GEO0;
                end
            end
            // plane and total registers settle from the size registers
            S_GEO0: n_state = S_GEO1;
            S_GEO1: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVP;
            end
            S_DIVP: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel_rem = 1'b1;
                    n_state           = S_DIVR;
                end
            end
            S_DIVR: if (i_sts.div_done) n_state = S_CHK;
            S_CHK: begin
                n_op    = OP_RD_XM;
                n_state = i_sts.emit ? S_OP : S_COMMIT;
            end
            S_OP: begin
                o_cmd.go = 1'b1;
                if (is_mul_op(r_op)) begin
                    n_state = S_WAIT;
                end else if (r_op == OP_ACC) begin
                    n_state = S_COMMIT;
                end else begin
                    n_op = t_op'(r_op + 5'd1);
                end
            end
            S_WAIT: begin
                if (i_sts.mul_done) begin
                    n_op    = t_op'(r_op + 5'd1);
                    n_state = S_OP;
                end
            end
            S_COMMIT: begin
                if (!i_sts.emit || i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_RD_XM;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `JSS_ASSERT_IMP(a_mul_wait, i_clk, i_rst_n, i_sts.mul_done, r_state == S_WAIT)

endmodule

// ----- rtl/jacobi_stencil_sweep_3d_top.sv -----
// ----------------------------------------------------------------------------
// jacobi_stencil_sweep_3d_top
// relaxed jacobi sweep of a 7-point 3d stencil over a padded raster stream
// ----------------------------------------------------------------------------
// one word at a time: the next word waits until the current one commits; a halo
//   word runs the two bit-serial index divisions over PW bits (PW = position
//   bits, 19 at MAX_EDGE 64), an interior word also six multi-cycle multiplies
// the result sits in an output register, so the next word is taken while
//   it waits on i_out_stall; the next result holds at commit until it leaves
// synchronous active-low reset clears position, residual sum, output valid
//   and restores the config defaults; plane stores are not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jacobi_stencil_sweep_3d_top #(
    parameter int MAX_EDGE = jss_pkg::MAX_EDGE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [jss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [jss_pkg::CFG_W-1:0]     i_cfg_data,
    // input word channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  jss_pkg::t_in_word             i_in_word,
    // result word channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output jss_pkg::t_out_word            o_out_word
);
    import jss_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    // sequencer
    jss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // stores, divider, multiplier and result register
    jss_dp #(.MAX_EDGE(MAX_EDGE)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

    // an accepted word holds off the next one
    `JSS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

// ----- dv/jss_sweep_checker.sv -----
// ----------------------------------------------------------------------------
// jss_sweep_checker
// watches the config, sample and result channels of the stencil sweep block,
// predicts every updated interior value and compares it word by word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jss_sweep_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [jss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [jss_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  jss_pkg::t_in_word             i_in_word,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  jss_pkg::t_out_word            i_out_word,
    output int                            o_fail_count,
    output int                            o_pending
);
    import jss_pkg::*;

    localparam int PAD_EDGE  = 66;
    localparam int PLANE_CAP = PAD_EDGE * PAD_EDGE;
    localparam longint LMAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint LMIN  = 64'sh8000_0000_0000_0000;

    logic [47:0]        wt_x, wt_y, wt_z;
    logic [39:0]        inv_centre;
    logic [17:0]        relax;
    logic [6:0]         edge_x, edge_y, edge_z;
    logic signed [31:0] u_planes [2*PLANE_CAP];
    logic signed [31:0] f_plane [PLANE_CAP];
    int unsigned        raster_pos;
    logic [63:0]        resid_acc;
    t_out_word          expected_words [$];
    int                 fails;

    function automatic longint sat_arith(input longint a, input longint b, input bit sub);
        logic [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) return s[64] ? LMIN : LMAX;
        return longint'(s[63:0]);
    endfunction

    function automatic logic [63:0] magnitude(input longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    // magnitude product, rounded half away from zero, shifted, signed saturated
    function automatic longint scaled_product(input bit neg, input logic [63:0] a,
                                              input logic [63:0] b, input int sh);
        logic [128:0] v;
        v = ({65'b0, a} * {65'b0, b} + (129'd1 << (sh - 1))) >> sh;
        if (neg) begin
            if (v >= (129'd1 << 63)) return LMIN;
            return -longint'(v[63:0]);
        end
        if (v > 129'(LMAX)) return LMAX;
        return longint'(v[63:0]);
    endfunction

    function automatic longint axis_term(input logic [47:0] wt, input longint a, input longint b);
        longint s;
        s = a + b;
        return scaled_product(s < 0, magnitude(s), {16'b0, wt}, 16);
    endfunction

    task automatic predict_word(input t_in_word w);
        int unsigned sx, sy, sz, pz, plane, span, total, p, ip, rem, j, k, s2, s1, c;
        longint uc, fv, tx, ty, tz, numer, rc, q, partial, rt, nv;
        logic [127:0] sq;
        t_out_word e;
        sx = edge_x > 64 ? 64 : edge_x;
        sy = edge_y > 64 ? 64 : edge_y;
        sz = edge_z > 64 ? 64 : edge_z;
        pz = sz + 2;
        plane = (sy + 2) * pz;
        span = 2 * plane;
        total = (sx + 2) * plane;
        p = raster_pos;
        ip = p / plane;
        rem = p % plane;
        j = rem / pz;
        k = rem % pz;
        s2 = p % span;
        s1 = p % plane;
        if (ip >= 2 && ip <= sx + 1 && j >= 1 && j <= sy && k >= 1 && k <= sz) begin
            c = p - plane;
            uc = u_planes[c % span];
            fv = f_plane[s1];
            tx = axis_term(wt_x, u_planes[s2], w.u_sample);
            ty = axis_term(wt_y, u_planes[(c - pz) % span], u_planes[(c + pz) % span]);
            tz = axis_term(wt_z, u_planes[(c - 1) % span], u_planes[(c + 1) % span]);
            numer = sat_arith(sat_arith(sat_arith(tx, ty, 1'b0), tz, 1'b0), fv, 1'b1);
            rc = {{24{inv_centre[39]}}, inv_centre};
            q = scaled_product((numer < 0) != (rc < 0), magnitude(numer), magnitude(rc), 32);
            partial = sat_arith(uc, q, 1'b0);
            rt = scaled_product(partial < 0, magnitude(partial), {46'b0, relax}, 16);
            nv = sat_arith(uc, rt, 1'b1);
            if (nv > 64'sd2147483647) nv = 64'sd2147483647;
            if (nv < -64'sd2147483648) nv = -64'sd2147483648;
            sq = {64'b0, magnitude(partial)} * {64'b0, magnitude(partial)};
            if (sq > {65'b0, SAT63}) sq = {65'b0, SAT63};
            resid_acc = resid_acc + sq[63:0];
            if (resid_acc > {1'b0, SAT63}) resid_acc = {1'b0, SAT63};
            e.new_value    = nv[31:0];
            e.residual_sum = resid_acc[62:0];
            e.last_point   = (ip - 1 == sx && j == sy && k == sz);
            expected_words.push_back(e);
        end
        u_planes[s2] = w.u_sample;
        f_plane[s1]  = w.f_sample;
        if (p + 1 >= total) begin
            raster_pos = 0;
            resid_acc  = 0;
        end else begin
            raster_pos = p + 1;
        end
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word e;
        if (expected_words.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("unexpected result word %h at %0t", got, $realtime);
            return;
        end
        e = expected_words.pop_front();
        if (got.new_value !== e.new_value || got.residual_sum !== e.residual_sum ||
            got.last_point !== e.last_point) begin
            fails++;
            if (fails <= 10)
                $display("mismatch at %0t: value %0d/%0d sum %h/%h last %b/%b (exp/act)",
                         $realtime, e.new_value, got.new_value, e.residual_sum,
                         got.residual_sum, e.last_point, got.last_point);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wt_x = COEF_RST;
            wt_y = COEF_RST;
            wt_z = COEF_RST;
            inv_centre = RECIP_RST;
            relax = RELAX_RST;
            edge_x = SIZE_RST;
            edge_y = SIZE_RST;
            edge_z = SIZE_RST;
            raster_pos = 0;
            resid_acc = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_COEF_X:       wt_x = i_cfg_data[47:0];
                    REG_COEF_Y:       wt_y = i_cfg_data[47:0];
                    REG_COEF_Z:       wt_z = i_cfg_data[47:0];
                    REG_CENTRE_RECIP: inv_centre = i_cfg_data[39:0];
                    REG_RELAX:        relax = i_cfg_data[17:0];
                    REG_SIZE_X:       edge_x = i_cfg_data[6:0];
                    REG_SIZE_Y:       edge_y = i_cfg_data[6:0];
                    REG_SIZE_Z:       edge_z = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_word(i_in_word);
            if (i_out_valid && !i_out_stall) check_word(i_out_word);
        end
        o_fail_count = fails;
        o_pending = expected_words.size();
    end

endmodule

// ----- dv/tb_jacobi_stencil_sweep_3d_top.sv -----
// ----------------------------------------------------------------------------
// tb_jacobi_stencil_sweep_3d_top
// drives whole padded sweeps into the stencil block under changing register
// settings with random gaps and output stalls; a checker beside the block
// predicts and compares every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_jacobi_stencil_sweep_3d_top;
    import jss_pkg::*;

    localparam int TARGET_WORDS = 1550;
    localparam int SETTLE_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_word             i_in_word;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_word            o_out_word;

    int fail_count;
    int pending;
    int words_sent;
    int idle_cycles;
    bit in_burst;
    int edge_x, edge_y, edge_z;   // sizes as last programmed, clamped to 64

    jacobi_stencil_sweep_3d_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    jss_sweep_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // watchdog: any accepted word on any channel restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: before each word a random stall, with
    // stretches of no stall at all so back-to-back results get exercised
    initial begin : result_stall
        int hold;
        int run_left;
        bit no_stall;
        i_out_stall = 1'b0;
        run_left = 0;
        no_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (run_left == 0) begin
                no_stall = ($urandom_range(0, 3) == 0);
                run_left = $urandom_range(8, 40);
            end
            run_left--;
            hold = no_stall ? 0 : $urandom_range(0, 10);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // one register write, held until the block takes it
    task automatic write_reg(input t_reg idx, input logic [CFG_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic program_all(input logic [47:0] cx, input logic [47:0] cy,
                               input logic [47:0] cz, input logic [39:0] recip,
                               input logic [17:0] rf, input int sx, input int sy,
                               input int sz);
        write_reg(REG_COEF_X, cx);
        write_reg(REG_COEF_Y, cy);
        write_reg(REG_COEF_Z, cz);
        write_reg(REG_CENTRE_RECIP, {8'b0, recip});
        write_reg(REG_RELAX, {30'b0, rf});
        write_reg(REG_SIZE_X, CFG_W'(sx));
        write_reg(REG_SIZE_Y, CFG_W'(sy));
        write_reg(REG_SIZE_Z, CFG_W'(sz));
        edge_x = sx > 64 ? 64 : sx;
        edge_y = sy > 64 ? 64 : sy;
        edge_z = sz > 64 ? 64 : sz;
    endtask

    // one grid word; a random gap first unless in a burst. valid stays up
    // across back-to-back words, so it is only ever set once per step
    task automatic send_word(input logic signed [31:0] u, input logic signed [31:0] f);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word.u_sample = u;
        i_in_word.f_sample = f;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        words_sent++;
        if ($urandom_range(0, 63) == 0) in_burst = ~in_burst;
    endtask

    // drop valid, wait until every predicted word came back, then let the
    // block finish any halo word it may still be chewing on
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2, 3, 4: return $urandom;
            default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        endcase
    endfunction

    // one full padded sweep at the programmed sizes
    task automatic random_sweep();
        int total;
        total = (edge_x + 2) * (edge_y + 2) * (edge_z + 2);
        repeat (total) send_word(rand_sample(), rand_sample());
    endtask

    function automatic logic [47:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return 48'd0;
            1: return {48{1'b1}};
            2, 3: return 48'({$urandom, $urandom});
            default: return 48'($urandom_range(0, 4 * 65536));
        endcase
    endfunction

    function automatic logic [39:0] rand_recip();
        case ($urandom_range(0, 7))
            0: return 40'd0;
            1: return 40'h80_0000_0000;
            2, 3: return -{1'b0, 39'({$urandom, $urandom})};
            default: return -40'($urandom_range(0, 32'h7FFF_FFFF));
        endcase
    endfunction

    function automatic logic [17:0] rand_relax();
        case ($urandom_range(0, 5))
            0: return 18'd0;
            1: return 18'd131072;
            default: return 18'($urandom_range(0, 131072));
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] corner [6];
        int sel, axis, sx, sy, sz, reps;
        corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        words_sent  = 0;
        in_burst    = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // smallest grid with default weights, corner values on u and f
        program_all(COEF_RST, COEF_RST, COEF_RST, RECIP_RST, RELAX_RST, 1, 1, 1);
        for (int i = 0; i < 27; i++) send_word(corner[i % 6], corner[(i + 3) % 6]);
        settle();
        // largest weights, most negative reciprocal, full relaxation: saturation
        program_all({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, 40'h80_0000_0000, 18'd131072,
                    1, 1, 1);
        for (int i = 0; i < 27; i++) send_word(corner[(i + 1) % 6], corner[(i + 2) % 6]);
        settle();
        // zero interior size: halo only, no results
        program_all(COEF_RST, COEF_RST, COEF_RST, RECIP_RST, RELAX_RST, 0, 1, 1);
        random_sweep();
        settle();
        // zero weights, zero reciprocal, no relaxation on a 2x2x2 interior
        program_all(48'd0, 48'd0, 48'd0, 40'd0, 18'd0, 2, 2, 2);
        random_sweep();
        settle();

        while (words_sent < TARGET_WORDS) begin
            sel = $urandom_range(0, 19);
            sx = $urandom_range(1, 4);
            sy = $urandom_range(1, 4);
            sz = $urandom_range(1, 4);
            if (sel == 0 && words_sent + 600 <= TARGET_WORDS) begin
                // one long axis, possibly past the edge limit where it clamps
                axis = $urandom_range(0, 2);
                sx = axis == 0 ? $urandom_range(64, 127) : 1;
                sy = axis == 1 ? $urandom_range(64, 127) : 1;
                sz = axis == 2 ? $urandom_range(64, 127) : 1;
            end else if (sel == 1) begin
                axis = $urandom_range(0, 2);
                if (axis == 0) sx = 0;
                if (axis == 1) sy = 0;
                if (axis == 2) sz = 0;
            end
            program_all(rand_coef(), rand_coef(), rand_coef(), rand_recip(), rand_relax(),
                        sx, sy, sz);
            reps = $urandom_range(1, 3);
            for (int r = 0; r < reps && words_sent < TARGET_WORDS; r++) random_sweep();
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
